/* rtl/stm_pkg.sv */
// shared constants, codes, control struct and font rom for the marquee
// no dependencies; used by all other files but stm_out_if
package stm_pkg;

  localparam int CELL_W     = 11;
  localparam int CELL_H     = 14;
  localparam int TOP_ROW    = 3;
  localparam int BLANK_CODE = 36;

  localparam int GLYPH_W    = 6;
  localparam int ACTION_W   = 2;
  localparam int SLOT_W     = 5;
  localparam int CODE_W     = 8;
  localparam int VROW_W     = 5;
  localparam int VCOL_W     = 7;
  localparam int FPOS_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int DIR_W      = 2;
  localparam int LEN_W      = 6;

  localparam int DEF_MAX_CHARS  = 32;
  localparam int DEF_VIEW_WIDTH = 75;
  localparam int DEF_VIEW_ROWS  = 20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR = 1'b0,
    CFG_LEN = 1'b1
  } cfg_reg_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef struct packed {
    logic valid;
    logic write;
    logic blank;
  } stm_ctl_t;

  function automatic logic [GLYPH_W-1:0] encode_char(input logic [CODE_W-1:0] c);
    logic [GLYPH_W-1:0] g;
    g = GLYPH_W'(BLANK_CODE);
    if (c >= 8'h61 && c <= 8'h7a) g = GLYPH_W'(c - 8'h61);
    else if (c >= 8'h30 && c <= 8'h39) g = GLYPH_W'(c - 8'h30 + 8'd26);
    return g;
  endfunction

  // ten rows of seven pixels, first row in the top bits
  function automatic logic [69:0] font_rows(input logic [GLYPH_W-1:0] code);
    logic [69:0] r;
    unique case (code)
      6'd0:  r = {7'h08,7'h14,7'h14,7'h14,7'h22,7'h3E,7'h22,7'h41,7'h41,7'h41};
      6'd1:  r = {7'h7C,7'h42,7'h42,7'h42,7'h7C,7'h42,7'h41,7'h41,7'h41,7'h7E};
      6'd2:  r = {7'h3E,7'h41,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h41,7'h3E};
      6'd3:  r = {7'h7C,7'h42,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h42,7'h7C};
      6'd4:  r = {7'h7F,7'h40,7'h40,7'h40,7'h40,7'h7E,7'h40,7'h40,7'h40,7'h7F};
      6'd5:  r = {7'h7F,7'h40,7'h40,7'h40,7'h40,7'h7E,7'h40,7'h40,7'h40,7'h40};
      6'd6:  r = {7'h3E,7'h41,7'h40,7'h40,7'h5F,7'h51,7'h41,7'h41,7'h41,7'h3E};
      6'd7:  r = {7'h41,7'h41,7'h41,7'h41,7'h41,7'h7F,7'h41,7'h41,7'h41,7'h41};
      6'd8:  r = {7'h7F,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h7F};
      6'd9:  r = {7'h01,7'h01,7'h01,7'h01,7'h01,7'h01,7'h01,7'h41,7'h41,7'h3E};
      6'd10: r = {7'h41,7'h42,7'h44,7'h48,7'h50,7'h70,7'h48,7'h44,7'h42,7'h41};
      6'd11: r = {7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h7F};
      6'd12: r = {7'h41,7'h63,7'h55,7'h49,7'h49,7'h49,7'h41,7'h41,7'h41,7'h41};
      6'd13: r = {7'h41,7'h61,7'h51,7'h51,7'h49,7'h49,7'h45,7'h45,7'h43,7'h41};
      6'd14: r = {7'h3E,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h3E};
      6'd15: r = {7'h7E,7'h41,7'h41,7'h41,7'h41,7'h7E,7'h40,7'h40,7'h40,7'h40};
      6'd16: r = {7'h3E,7'h41,7'h41,7'h41,7'h41,7'h41,7'h49,7'h45,7'h42,7'h3D};
      6'd17: r = {7'h7E,7'h41,7'h41,7'h41,7'h41,7'h7E,7'h48,7'h44,7'h42,7'h41};
      6'd18: r = {7'h3E,7'h41,7'h40,7'h40,7'h3E,7'h01,7'h01,7'h01,7'h41,7'h3E};
      6'd19: r = {7'h7F,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08};
      6'd20: r = {7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h3E};
      6'd21: r = {7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h22,7'h14,7'h08};
      6'd22: r = {7'h41,7'h41,7'h41,7'h49,7'h49,7'h49,7'h49,7'h49,7'h49,7'h36};
      6'd23: r = {7'h41,7'h22,7'h22,7'h14,7'h14,7'h08,7'h14,7'h22,7'h22,7'h41};
      6'd24: r = {7'h41,7'h22,7'h14,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08};
      6'd25: r = {7'h7F,7'h01,7'h02,7'h04,7'h08,7'h08,7'h10,7'h20,7'h40,7'h7F};
      6'd26: r = {7'h3E,7'h61,7'h51,7'h51,7'h49,7'h49,7'h45,7'h45,7'h43,7'h3E};
      6'd27: r = {7'h08,7'h18,7'h28,7'h48,7'h08,7'h08,7'h08,7'h08,7'h08,7'h7F};
      6'd28: r = {7'h3E,7'h41,7'h01,7'h01,7'h02,7'h04,7'h08,7'h10,7'h20,7'h7F};
      6'd29: r = {7'h3E,7'h41,7'h01,7'h01,7'h3E,7'h01,7'h01,7'h01,7'h41,7'h3E};
      6'd30: r = {7'h08,7'h18,7'h28,7'h48,7'h48,7'h7F,7'h08,7'h08,7'h08,7'h08};
      6'd31: r = {7'h7F,7'h40,7'h40,7'h40,7'h7E,7'h01,7'h01,7'h01,7'h41,7'h3E};
      6'd32: r = {7'h3E,7'h41,7'h40,7'h40,7'h7E,7'h41,7'h41,7'h41,7'h41,7'h3E};
      6'd33: r = {7'h7F,7'h01,7'h02,7'h04,7'h08,7'h10,7'h10,7'h10,7'h10,7'h10};
      6'd34: r = {7'h3E,7'h41,7'h41,7'h41,7'h3E,7'h41,7'h41,7'h41,7'h41,7'h3E};
      6'd35: r = {7'h3E,7'h41,7'h41,7'h41,7'h3F,7'h01,7'h01,7'h01,7'h41,7'h3E};
      default: r = '0;
    endcase
    return r;
  endfunction

  // fr is the font row (2..11), fc the font column (2..8)
  function automatic logic font_bit(input logic [GLYPH_W-1:0] code,
                                    input logic [FPOS_W-1:0] fr,
                                    input logic [FPOS_W-1:0] fc);
    logic [69:0] rows;
    logic [FPOS_W-1:0] ri;
    logic [FPOS_W-1:0] bi;
    logic [6:0] line;
    rows = font_rows(code);
    ri = fr - 4'd2;
    bi = 4'd8 - fc;
    line = 7'(rows >> (7 * (9 - int'(ri))));
    return line[bi[2:0]];
  endfunction

endpackage

/* rtl/stm_in_if.sv */
// input channel of the marquee: valid/ready handshake with one item payload
// depends on stm_pkg
interface stm_in_if;
  import stm_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   char_slot;
  logic [CODE_W-1:0]   char_code;
  logic [VROW_W-1:0]   view_row;
  logic [VCOL_W-1:0]   view_col;

  modport source (output valid, action, char_slot, char_code, view_row, view_col,
                  input ready);
  modport sink (input valid, action, char_slot, char_code, view_row, view_col,
                output ready);
endinterface

/* rtl/stm_out_if.sv */
// output channel of the marquee: valid/ready handshake with one pixel
// no dependencies
interface stm_out_if;
  logic valid;
  logic ready;
  logic pixel_on;

  modport source (output valid, pixel_on, input ready);
  modport sink (input valid, pixel_on, output ready);
endinterface

/* rtl/stm_scroll.sv */
// input register, scroll offset and window-to-canvas mapping
// depends on stm_pkg and stm_in_if
module stm_scroll #(
  parameter int VIEW_WIDTH = stm_pkg::DEF_VIEW_WIDTH,
  parameter int VIEW_ROWS  = stm_pkg::DEF_VIEW_ROWS,
  parameter int PER_W      = 9,
  parameter int ROW_W      = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  stm_in_if.sink                   req,
  input  stm_pkg::dir_t            dir,
  input  logic [PER_W-1:0]         hperiod,
  input  logic                     clr,
  output stm_pkg::stm_ctl_t        b_ctl,
  output logic [PER_W-1:0]         b_col,
  output logic [ROW_W-1:0]         b_row,
  output logic [stm_pkg::SLOT_W-1:0]  b_slot,
  output logic [stm_pkg::GLYPH_W-1:0] b_glyph,
  input  logic                     b_ready
);
  import stm_pkg::*;

  localparam logic [ROW_W:0] VR = (ROW_W + 1)'(VIEW_ROWS);

  logic                a_valid;
  logic [ACTION_W-1:0] a_action;
  logic [SLOT_W-1:0]   a_slot;
  logic [CODE_W-1:0]   a_code;
  logic [VROW_W-1:0]   a_row;
  logic [VCOL_W-1:0]   a_col;

  logic [PER_W-1:0] offset;
  logic [PER_W-1:0] offset_next;
  logic [PER_W-1:0] cur_p;
  logic [PER_W-1:0] inc;

  logic             a_pass;
  logic             a_go;
  logic             b_free;
  logic             in_win;
  logic [PER_W:0]   hs;
  logic [PER_W-1:0] hc;
  logic [ROW_W:0]   vs;
  logic [ROW_W-1:0] vc;
  logic [PER_W-1:0] map_col;
  logic [ROW_W-1:0] map_row;

  assign a_pass    = (a_action == ACT_WRITE) || (a_action == ACT_READ);
  assign b_free    = !b_ctl.valid || b_ready;
  assign a_go      = a_valid && (!a_pass || b_free);
  assign req.ready = !a_valid || a_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req.ready) begin
      a_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      a_action <= req.action;
      a_slot   <= req.char_slot;
      a_code   <= req.char_code;
      a_row    <= req.view_row;
      a_col    <= req.view_col;
    end
  end

  // offset stays below the period of the current direction
  always_comb begin
    cur_p = (dir == DIR_UP || dir == DIR_DOWN) ? PER_W'(VIEW_ROWS) : hperiod;
    inc = offset + PER_W'(1);
    offset_next = (inc >= cur_p) ? '0 : inc;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      offset <= '0;
    end else if (a_go && a_action == ACT_TICK) begin
      offset <= offset_next;
    end
  end

  always_comb begin
    in_win = (int'(a_row) < VIEW_ROWS) && (int'(a_col) < VIEW_WIDTH);
    hs = '0;
    vs = '0;
    unique case (dir)
      DIR_LEFT:  hs = (PER_W + 1)'(a_col) + {1'b0, offset};
      DIR_RIGHT: hs = (PER_W + 1)'(a_col) + {1'b0, hperiod} - {1'b0, offset};
      DIR_UP:    vs = (ROW_W + 1)'(a_row) + (ROW_W + 1)'(offset);
      DIR_DOWN:  vs = (ROW_W + 1)'(a_row) + VR - (ROW_W + 1)'(offset);
    endcase
    hc = (hs >= {1'b0, hperiod}) ? PER_W'(hs - {1'b0, hperiod}) : PER_W'(hs);
    vc = (vs >= VR) ? ROW_W'(vs - VR) : ROW_W'(vs);
    if (dir == DIR_UP || dir == DIR_DOWN) begin
      map_col = PER_W'(a_col);
      map_row = vc;
    end else begin
      map_col = hc;
      map_row = ROW_W'(a_row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl <= '0;
    end else if (a_go && a_pass) begin
      b_ctl.valid <= 1'b1;
      b_ctl.write <= (a_action == ACT_WRITE);
      b_ctl.blank <= !in_win;
    end else if (b_ready) begin
      b_ctl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_pass) begin
      b_col   <= map_col;
      b_row   <= map_row;
      b_slot  <= a_slot;
      b_glyph <= encode_char(a_code);
    end
  end

endmodule

/* rtl/stm_glyph.sv */
// glyph store and canvas column split into character slot and font column
// depends on stm_pkg
module stm_glyph #(
  parameter int MAX_CHARS = stm_pkg::DEF_MAX_CHARS,
  parameter int PER_W     = 9,
  parameter int ROW_W     = 5,
  parameter int SPAN_W    = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  stm_pkg::stm_ctl_t           b_ctl,
  input  logic [PER_W-1:0]            b_col,
  input  logic [ROW_W-1:0]            b_row,
  input  logic [stm_pkg::SLOT_W-1:0]  b_slot,
  input  logic [stm_pkg::GLYPH_W-1:0] b_glyph,
  input  logic [SPAN_W-1:0]           span,
  output logic                        b_ready,
  output stm_pkg::stm_ctl_t           c_ctl,
  output logic [stm_pkg::GLYPH_W-1:0] c_glyph,
  output logic [stm_pkg::FPOS_W-1:0]  c_fr,
  output logic [stm_pkg::FPOS_W-1:0]  c_fc,
  input  logic                        c_ready
);
  import stm_pkg::*;

  localparam int AW  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int K   = PER_W + 1;
  localparam int M   = (2 ** K) / CELL_W;
  localparam int MW  = $clog2(M + 1);
  localparam int PW  = PER_W + MW;
  localparam int RW  = PER_W + 1;

  logic [GLYPH_W-1:0] store [MAX_CHARS];
  logic [MAX_CHARS-1:0] written;

  logic [PW-1:0]     prod;
  logic [PER_W-1:0]  q0;
  logic [RW-1:0]     r0;
  logic              fix;
  logic [PER_W-1:0]  slot;
  logic [FPOS_W-1:0] fc;
  logic [FPOS_W-1:0] fr;
  logic              blank;
  logic              c_free;
  logic              c_load;
  logic              wr_en;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [GLYPH_W-1:0] rd_glyph;
  logic              rd_ok;
  logic              blank_q;
  logic              c_valid;
  logic              row_out;

  // divide by the cell width through a reciprocal, one correction step
  always_comb begin
    prod = PW'(b_col) * PW'(M);
    q0   = PER_W'(prod >> K);
    r0   = RW'(b_col) - RW'(q0) * RW'(CELL_W);
    fix  = (r0 >= RW'(CELL_W));
    slot = fix ? q0 + PER_W'(1) : q0;
    fc   = fix ? FPOS_W'(r0 - RW'(CELL_W)) : FPOS_W'(r0);
    fr   = FPOS_W'(b_row - ROW_W'(TOP_ROW));
    row_out = (int'(b_row) < TOP_ROW + 2) || (int'(b_row) > TOP_ROW + 11);
    blank = b_ctl.blank || (PER_W'(span) <= b_col) || row_out
            || (fc < 4'd2) || (fc > 4'd8);
  end

  assign c_free  = !c_valid || c_ready;
  assign b_ready = b_ctl.write || c_free;
  assign c_load  = b_ctl.valid && !b_ctl.write && c_free;
  assign wr_en   = b_ctl.valid && b_ctl.write && (int'(b_slot) < MAX_CHARS);
  assign waddr   = AW'(b_slot);
  assign raddr   = AW'(slot);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[waddr] <= b_glyph;
    end
    if (c_load) begin
      rd_glyph <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[waddr] <= 1'b1;
      end
      if (c_load) begin
        rd_ok <= written[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_load) begin
      c_valid <= 1'b1;
    end else if (c_ready) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      blank_q <= blank;
      c_fr    <= fr;
      c_fc    <= fc;
    end
  end

  assign c_ctl   = '{valid: c_valid, write: 1'b0, blank: blank_q};
  assign c_glyph = rd_ok ? rd_glyph : GLYPH_W'(BLANK_CODE);

endmodule

/* rtl/stm_font.sv */
// font rom lookup and result register
// depends on stm_pkg and stm_out_if
module stm_font (
  input  logic                        clk,
  input  logic                        rst,
  input  stm_pkg::stm_ctl_t           c_ctl,
  input  logic [stm_pkg::GLYPH_W-1:0] c_glyph,
  input  logic [stm_pkg::FPOS_W-1:0]  c_fr,
  input  logic [stm_pkg::FPOS_W-1:0]  c_fc,
  output logic                        c_ready,
  stm_out_if.source                   rsp
);
  import stm_pkg::*;

  logic out_valid;
  logic pixel;

  assign c_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_ready) begin
      out_valid <= c_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && c_ctl.valid) begin
      pixel <= !c_ctl.blank && font_bit(c_glyph, c_fr, c_fc);
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.pixel_on = pixel;

endmodule

/* rtl/scrolling_text_marquee_unit.sv */
// Scrolling text marquee. Takes one item per clock unless stalled (write
// glyph, tick, read pixel) and returns one pixel per read item via scroll,
// glyph and font stages. The rate is set by a single-port glyph store that is
// written and read at the same pipeline step; a write followed by a read of
// that slot sees the new glyph. Writing either register resets the scroll
// offset. No clearing pass after reset: slots never written read as blank.
module scrolling_text_marquee_unit #(
  parameter int MAX_CHARS  = stm_pkg::DEF_MAX_CHARS,
  parameter int VIEW_WIDTH = stm_pkg::DEF_VIEW_WIDTH,
  parameter int VIEW_ROWS  = stm_pkg::DEF_VIEW_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  stm_in_if.sink                         req,
  stm_out_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [stm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import stm_pkg::*;

  localparam int ACT_W  = $clog2(MAX_CHARS + 1);
  localparam int SPAN_W = $clog2(MAX_CHARS * CELL_W + 1);
  localparam int HMAX   = (MAX_CHARS * CELL_W > VIEW_WIDTH) ? MAX_CHARS * CELL_W : VIEW_WIDTH;
  localparam int MAXP   = (HMAX > VIEW_ROWS) ? HMAX : VIEW_ROWS;
  localparam int PER_W  = $clog2(MAXP + 1);
  localparam int ROW_W  = $clog2(VIEW_ROWS);

  dir_t              dir;
  logic [LEN_W-1:0]  text_length;
  logic [ACT_W-1:0]  act_len;
  logic [SPAN_W-1:0] span;
  logic [PER_W-1:0]  hperiod;

  stm_ctl_t           b_ctl;
  logic [PER_W-1:0]   b_col;
  logic [ROW_W-1:0]   b_row;
  logic [SLOT_W-1:0]  b_slot;
  logic [GLYPH_W-1:0] b_glyph;
  logic               b_ready;

  stm_ctl_t           c_ctl;
  logic [GLYPH_W-1:0] c_glyph;
  logic [FPOS_W-1:0]  c_fr;
  logic [FPOS_W-1:0]  c_fc;
  logic               c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir         <= DIR_LEFT;
      text_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DIR: dir <= dir_t'(cfg_data[DIR_W-1:0]);
        CFG_LEN: text_length <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    act_len = (int'(text_length) > MAX_CHARS) ? ACT_W'(MAX_CHARS) : ACT_W'(text_length);
    span    = SPAN_W'(act_len) * SPAN_W'(CELL_W);
    hperiod = (PER_W'(span) < PER_W'(VIEW_WIDTH)) ? PER_W'(VIEW_WIDTH) : PER_W'(span);
  end

  stm_scroll #(
    .VIEW_WIDTH (VIEW_WIDTH),
    .VIEW_ROWS  (VIEW_ROWS),
    .PER_W      (PER_W),
    .ROW_W      (ROW_W)
  ) u_scroll (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .dir     (dir),
    .hperiod (hperiod),
    .clr     (cfg_we),
    .b_ctl   (b_ctl),
    .b_col   (b_col),
    .b_row   (b_row),
    .b_slot  (b_slot),
    .b_glyph (b_glyph),
    .b_ready (b_ready)
  );

  stm_glyph #(
    .MAX_CHARS (MAX_CHARS),
    .PER_W     (PER_W),
    .ROW_W     (ROW_W),
    .SPAN_W    (SPAN_W)
  ) u_glyph (
    .clk     (clk),
    .rst     (rst),
    .b_ctl   (b_ctl),
    .b_col   (b_col),
    .b_row   (b_row),
    .b_slot  (b_slot),
    .b_glyph (b_glyph),
    .span    (span),
    .b_ready (b_ready),
    .c_ctl   (c_ctl),
    .c_glyph (c_glyph),
    .c_fr    (c_fr),
    .c_fc    (c_fc),
    .c_ready (c_ready)
  );

  stm_font u_font (
    .clk     (clk),
    .rst     (rst),
    .c_ctl   (c_ctl),
    .c_glyph (c_glyph),
    .c_fr    (c_fr),
    .c_fc    (c_fc),
    .c_ready (c_ready),
    .rsp     (rsp)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// self-checking bench for scrolling_text_marquee_unit: directed table, then random phases
// depends on stm_pkg, stm_in_if, stm_out_if and the rtl top level
module tb;
  import stm_pkg::*;

  localparam int MAX_CHARS  = DEF_MAX_CHARS;
  localparam int VIEW_WIDTH = DEF_VIEW_WIDTH;
  localparam int VIEW_ROWS  = DEF_VIEW_ROWS;
  localparam int FONT_TOP   = 3;
  localparam int SETTLE     = 8;
  localparam int LONG_HOLD  = 64;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASES     = 12;
  localparam int PHASE_ITEMS = 110;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [CODE_W-1:0]   code;
    logic [VROW_W-1:0]   row;
    logic [VCOL_W-1:0]   col;
  } marquee_item_t;

  typedef struct packed {
    bit                  is_cfg;
    logic [DIR_W-1:0]    dir;
    logic [LEN_W-1:0]    len;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [CODE_W-1:0]   code;
    logic [VROW_W-1:0]   row;
    logic [VCOL_W-1:0]   col;
    bit                  known;
    bit                  pix;
  } plan_row_t;

  localparam int PLAN_ROWS = 32;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd0,  7'd0,   1, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd19, 7'd74,  1, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd0,  "a",   5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd1,  "z",   5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd2,  "0",   5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd3,  "9",   5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd4,  8'hff, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd5,  8'h00, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd6,  8'h60, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd7,  8'h2f, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd8,  8'h3a, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd31, "q",   5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_WRITE,  5'd9,  " ",   5'd0,  7'd0,   0, 0},
    '{1, DIR_LEFT,  6'd63, ACT_READ,   5'd0,  8'h00, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd5,  7'd5,   1, 1},
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd31, 7'd127, 1, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd20, 7'd0,   1, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd0,  7'd75,  1, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_UNUSED, 5'd3,  "b",   5'd2,  7'd2,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_TICK,   5'd0,  8'h00, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd5,  7'd4,   0, 0},
    '{1, DIR_RIGHT, 6'd32, ACT_READ,   5'd0,  8'h00, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_TICK,   5'd0,  8'h00, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd5,  7'd0,   0, 0},
    '{1, DIR_UP,    6'd32, ACT_READ,   5'd0,  8'h00, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_TICK,   5'd0,  8'h00, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd4,  7'd5,   0, 0},
    '{1, DIR_DOWN,  6'd32, ACT_READ,   5'd0,  8'h00, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_TICK,   5'd0,  8'h00, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd6,  7'd5,   0, 0},
    '{1, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd0,  7'd0,   0, 0},
    '{0, DIR_LEFT,  6'd0,  ACT_READ,   5'd0,  8'h00, 5'd10, 7'd74,  1, 0}
  };

  localparam dir_t PHASE_DIR [PHASES] = '{
    DIR_LEFT, DIR_RIGHT, DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT,
    DIR_LEFT, DIR_DOWN, DIR_UP, DIR_RIGHT, DIR_LEFT, DIR_RIGHT
  };
  localparam logic [LEN_W-1:0] PHASE_LEN [PHASES] = '{
    6'd1, 6'd6, 6'd7, 6'd32, 6'd33, 6'd0, 6'd32, 6'd3, 6'd63, 6'd7, 6'd12, 6'd20
  };
  localparam int TICK_PCT [3] = '{10, 35, 70};

  // rows 2..11 of each cell, seven pixels per row, top row in the high bits
  localparam logic [69:0] FONT [37] = '{
    {7'h08,7'h14,7'h14,7'h14,7'h22,7'h3E,7'h22,7'h41,7'h41,7'h41},
    {7'h7C,7'h42,7'h42,7'h42,7'h7C,7'h42,7'h41,7'h41,7'h41,7'h7E},
    {7'h3E,7'h41,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h41,7'h3E},
    {7'h7C,7'h42,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h42,7'h7C},
    {7'h7F,7'h40,7'h40,7'h40,7'h40,7'h7E,7'h40,7'h40,7'h40,7'h7F},
    {7'h7F,7'h40,7'h40,7'h40,7'h40,7'h7E,7'h40,7'h40,7'h40,7'h40},
    {7'h3E,7'h41,7'h40,7'h40,7'h5F,7'h51,7'h41,7'h41,7'h41,7'h3E},
    {7'h41,7'h41,7'h41,7'h41,7'h41,7'h7F,7'h41,7'h41,7'h41,7'h41},
    {7'h7F,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h7F},
    {7'h01,7'h01,7'h01,7'h01,7'h01,7'h01,7'h01,7'h41,7'h41,7'h3E},
    {7'h41,7'h42,7'h44,7'h48,7'h50,7'h70,7'h48,7'h44,7'h42,7'h41},
    {7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h7F},
    {7'h41,7'h63,7'h55,7'h49,7'h49,7'h49,7'h41,7'h41,7'h41,7'h41},
    {7'h41,7'h61,7'h51,7'h51,7'h49,7'h49,7'h45,7'h45,7'h43,7'h41},
    {7'h3E,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h3E},
    {7'h7E,7'h41,7'h41,7'h41,7'h41,7'h7E,7'h40,7'h40,7'h40,7'h40},
    {7'h3E,7'h41,7'h41,7'h41,7'h41,7'h41,7'h49,7'h45,7'h42,7'h3D},
    {7'h7E,7'h41,7'h41,7'h41,7'h41,7'h7E,7'h48,7'h44,7'h42,7'h41},
    {7'h3E,7'h41,7'h40,7'h40,7'h3E,7'h01,7'h01,7'h01,7'h41,7'h3E},
    {7'h7F,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08},
    {7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h3E},
    {7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h22,7'h14,7'h08},
    {7'h41,7'h41,7'h41,7'h49,7'h49,7'h49,7'h49,7'h49,7'h49,7'h36},
    {7'h41,7'h22,7'h22,7'h14,7'h14,7'h08,7'h14,7'h22,7'h22,7'h41},
    {7'h41,7'h22,7'h14,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08},
    {7'h7F,7'h01,7'h02,7'h04,7'h08,7'h08,7'h10,7'h20,7'h40,7'h7F},
    {7'h3E,7'h61,7'h51,7'h51,7'h49,7'h49,7'h45,7'h45,7'h43,7'h3E},
    {7'h08,7'h18,7'h28,7'h48,7'h08,7'h08,7'h08,7'h08,7'h08,7'h7F},
    {7'h3E,7'h41,7'h01,7'h01,7'h02,7'h04,7'h08,7'h10,7'h20,7'h7F},
    {7'h3E,7'h41,7'h01,7'h01,7'h3E,7'h01,7'h01,7'h01,7'h41,7'h3E},
    {7'h08,7'h18,7'h28,7'h48,7'h48,7'h7F,7'h08,7'h08,7'h08,7'h08},
    {7'h7F,7'h40,7'h40,7'h40,7'h7E,7'h01,7'h01,7'h01,7'h41,7'h3E},
    {7'h3E,7'h41,7'h40,7'h40,7'h7E,7'h41,7'h41,7'h41,7'h41,7'h3E},
    {7'h7F,7'h01,7'h02,7'h04,7'h08,7'h10,7'h10,7'h10,7'h10,7'h10},
    {7'h3E,7'h41,7'h41,7'h41,7'h3E,7'h41,7'h41,7'h41,7'h41,7'h3E},
    {7'h3E,7'h41,7'h41,7'h41,7'h3F,7'h01,7'h01,7'h01,7'h41,7'h3E},
    70'd0
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stm_in_if  req_if ();
  stm_out_if rsp_if ();

  scrolling_text_marquee_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // marquee state as the bench sees it
  logic [GLYPH_W-1:0] glyph_mem [MAX_CHARS];
  dir_t               cur_dir;
  logic [LEN_W-1:0]   cur_len;
  int                 scroll_pos;

  logic pixel_due_q [$];
  int   bad_pixels = 0;
  bit   calm = 1'b0;
  bit   hold_long = 1'b0;
  int   idle_cycles = 0;

  function automatic int text_span();
    int n;
    n = (cur_len > MAX_CHARS) ? MAX_CHARS : int'(cur_len);
    return n * CELL_W;
  endfunction

  function automatic int h_period();
    return (text_span() < VIEW_WIDTH) ? VIEW_WIDTH : text_span();
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CODE_W-1:0] ch);
    if (ch >= "a" && ch <= "z") return GLYPH_W'(ch - "a");
    if (ch >= "0" && ch <= "9") return GLYPH_W'(ch - "0" + 26);
    return GLYPH_W'(BLANK_CODE);
  endfunction

  function automatic logic [CODE_W-1:0] glyph_char(input int k);
    if (k < 26) return CODE_W'("a" + k);
    if (k < 36) return CODE_W'("0" + k - 26);
    return CODE_W'(" ");
  endfunction

  function automatic logic lit_pixel(input logic [VROW_W-1:0] row,
                                     input logic [VCOL_W-1:0] col);
    int p, off, r, c, fr, fc;
    logic [69:0] rows;
    logic [6:0] line;
    if (row >= VIEW_ROWS || col >= VIEW_WIDTH) return 1'b0;
    r = row;
    c = col;
    if (cur_dir == DIR_LEFT || cur_dir == DIR_RIGHT) begin
      p = h_period();
      off = scroll_pos % p;
      c = (cur_dir == DIR_LEFT) ? (col + off) % p : (col + p - off) % p;
    end else begin
      off = scroll_pos % VIEW_ROWS;
      r = (cur_dir == DIR_UP) ? (row + off) % VIEW_ROWS : (row + VIEW_ROWS - off) % VIEW_ROWS;
    end
    if (c >= text_span() || r < FONT_TOP || r >= FONT_TOP + CELL_H) return 1'b0;
    fr = r - FONT_TOP;
    fc = c % CELL_W;
    if (fr < 2 || fr > 11 || fc < 2 || fc > 8) return 1'b0;
    rows = FONT[glyph_mem[c / CELL_W]];
    line = rows[7 * (11 - fr) +: 7];
    return line[8 - fc];
  endfunction

  function automatic void step_marquee(input marquee_item_t it, output bit yields,
                                       output bit lit);
    int p;
    yields = 1'b0;
    lit = 1'b0;
    case (it.action)
      ACT_WRITE: glyph_mem[it.slot] = glyph_of(it.code);
      ACT_TICK: begin
        p = (cur_dir == DIR_UP || cur_dir == DIR_DOWN) ? VIEW_ROWS : h_period();
        scroll_pos = (scroll_pos + 1 >= p) ? 0 : scroll_pos + 1;
      end
      ACT_READ: begin
        yields = 1'b1;
        lit = lit_pixel(it.row, it.col);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input marquee_item_t it, input bit known, input bit pix);
    int gap;
    bit yields, lit;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= it.action;
    req_if.char_slot <= it.slot;
    req_if.char_code <= it.code;
    req_if.view_row  <= it.row;
    req_if.view_col  <= it.col;
    do @(posedge clk); while (!req_if.ready);
    step_marquee(it, yields, lit);
    if (yields) pixel_due_q.push_back(known ? pix : lit);
  endtask

  task automatic drain(input int extra);
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pixel_due_q.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_config(input logic [DIR_W-1:0] dir, input logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-DIR_W-1:0] junk;
    junk = (CFG_DATA_W-DIR_W)'($urandom_range(0, 15));
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIR;
    cfg_data  <= {junk, dir};
    @(posedge clk);
    cur_dir = dir_t'(dir);
    scroll_pos = 0;
    cfg_index <= CFG_LEN;
    cfg_data  <= len;
    @(posedge clk);
    cur_len = len;
    scroll_pos = 0;
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int hold;
    logic want;
    hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        if (pixel_due_q.size() == 0) begin
          bad_pixels++;
          if (bad_pixels <= 10) $display("unexpected pixel item: pixel_on=%0b", rsp_if.pixel_on);
        end else begin
          want = pixel_due_q.pop_front();
          if (rsp_if.pixel_on !== want) begin
            bad_pixels++;
            if (bad_pixels <= 10)
              $display("pixel mismatch: expected %0b got %0b", want, rsp_if.pixel_on);
          end
        end
        hold = calm ? 0 : $urandom_range(0, 4);
      end else if (hold > 0) begin
        hold--;
      end
      if (hold_long) begin
        hold = LONG_HOLD;
        hold_long = 1'b0;
      end
      rsp_if.ready <= (hold == 0) && !rst;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("scrolling_text_marquee_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    marquee_item_t it;
    int tw, pick;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_DIR;
    cfg_data         <= '0;
    req_if.valid     <= 1'b0;
    req_if.action    <= ACT_WRITE;
    req_if.char_slot <= '0;
    req_if.char_code <= '0;
    req_if.view_row  <= '0;
    req_if.view_col  <= '0;
    foreach (glyph_mem[i]) glyph_mem[i] = GLYPH_W'(BLANK_CODE);
    cur_dir = DIR_LEFT;
    cur_len = '0;
    scroll_pos = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg) begin
        drain(SETTLE);
        set_config(PLAN[i].dir, PLAN[i].len);
      end else begin
        it = '{PLAN[i].action, PLAN[i].slot, PLAN[i].code, PLAN[i].row, PLAN[i].col};
        send_item(it, PLAN[i].known, PLAN[i].pix);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain(SETTLE);
      set_config(PHASE_DIR[ph], PHASE_LEN[ph]);
      calm = (ph % 4 == 3) || (ph == 2);
      tw = TICK_PCT[$urandom_range(0, 2)];
      if (ph == 2) hold_long = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == PHASE_ITEMS / 2) drain(0);
        it.action = ACT_READ;
        it.slot   = SLOT_W'($urandom_range(0, 31));
        it.code   = CODE_W'($urandom_range(0, 255));
        it.row    = VROW_W'($urandom_range(0, 31));
        it.col    = VCOL_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (ph == 0 && n < MAX_CHARS) begin
          // lay down a full message first
          it.action = ACT_WRITE;
          it.slot   = SLOT_W'(n);
          it.code   = glyph_char($urandom_range(0, 36));
        end else if (pick < tw) begin
          it.action = ACT_TICK;
        end else if (pick < tw + 15) begin
          it.action = ACT_WRITE;
          if ($urandom_range(0, 4) != 0) it.code = glyph_char($urandom_range(0, 36));
        end else if (pick < tw + 18) begin
          it.action = ACT_UNUSED;
        end else if ($urandom_range(0, 9) != 0) begin
          it.row = VROW_W'($urandom_range(0, VIEW_ROWS - 1));
          it.col = VCOL_W'($urandom_range(0, VIEW_WIDTH - 1));
        end
        send_item(it, 1'b0, 1'b0);
      end
    end

    drain(10);
    if (bad_pixels == 0) begin
      $display("scrolling_text_marquee_unit regression: pass");
    end else begin
      $display("scrolling_text_marquee_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/stm_pkg.sv
rtl/stm_in_if.sv
rtl/stm_out_if.sv
rtl/stm_scroll.sv
rtl/stm_glyph.sv
rtl/stm_font.sv
rtl/scrolling_text_marquee_unit.sv
bench/tb.sv
